>>> rtl/overheat_protection_timer_core_assert.svh
// Assertion macros used by the verification-side checker of the overheat
// protection timer. Each macro expands to one labeled concurrent assertion.
`ifndef OVERHEAT_PROTECTION_TIMER_CORE_ASSERT_SVH
`define OVERHEAT_PROTECTION_TIMER_CORE_ASSERT_SVH

// Checked at every rising clock edge while reset is not asserted.
`define OPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define OPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/opt_pkg.sv
// ----------------------------------------------------------------------------
// opt_pkg
// Types and constants of the overheat protection timer.
// ----------------------------------------------------------------------------
package opt_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 2;

    localparam logic [6:0] FINE_ROLL  = 7'd100;
    localparam logic [5:0] BUZZ_TICKS = 6'd50;
    localparam logic [6:0] BUZZ_AT    = 7'd10;

    localparam logic       RST_PROTECT_ENABLE = 1'b0;
    localparam logic [7:0] RST_HEAT_TIME_LIMIT = 8'd15;
    localparam logic [6:0] RST_COOLDOWN_STEPS = 7'd50;
    localparam logic [7:0] RST_STEP_TICKS = 8'd133;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROTECT_ENABLE  = 2'd0,
        REG_HEAT_TIME_LIMIT = 2'd1,
        REG_COOLDOWN_STEPS  = 2'd2,
        REG_STEP_TICKS      = 2'd3
    } t_reg_idx;

    typedef enum logic [OUT_USER_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_REMAIN = 2'd1,
        KIND_END    = 2'd2
    } t_report_kind;

    typedef struct packed {
        logic       protect_enable;
        logic [7:0] heat_time_limit;
        logic [6:0] cooldown_steps;
        logic [7:0] step_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] temperature;
        logic       power_on;
        logic       heat_b_on;
        logic       heat_a_on;
    } t_in;

    typedef struct packed {
        logic         link_notify;
        logic [7:0]   report_value;
        t_report_kind report_kind;
        logic         buzzer_drive;
        logic         cooldown_done;
        logic         cooldown_active;
    } t_out;

endpackage

>>> rtl/opt_cfg.sv
// ----------------------------------------------------------------------------
// opt_cfg
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module opt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [opt_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [opt_pkg::CFG_DATA_W-1:0]  i_data,
    output opt_pkg::t_cfg                  o_cfg
);
    import opt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protect_enable  <= RST_PROTECT_ENABLE;
            r_cfg.heat_time_limit <= RST_HEAT_TIME_LIMIT;
            r_cfg.cooldown_steps  <= RST_COOLDOWN_STEPS;
            r_cfg.step_ticks      <= RST_STEP_TICKS;
        end else if (i_wr_en) begin
            unique case (t_reg_idx'(i_index))
                REG_PROTECT_ENABLE:  r_cfg.protect_enable  <= i_data[0];
                REG_HEAT_TIME_LIMIT: r_cfg.heat_time_limit <= i_data;
                REG_COOLDOWN_STEPS:  r_cfg.cooldown_steps  <= i_data[6:0];
                REG_STEP_TICKS:      r_cfg.step_ticks      <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/opt_core.sv
// ----------------------------------------------------------------------------
// opt_core
// Timer state and the one-tick update: heating count, cooldown, buzzer.
// ----------------------------------------------------------------------------
module opt_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  opt_pkg::t_cfg i_cfg,
    input  opt_pkg::t_in  i_item,
    output opt_pkg::t_out o_result
);
    import opt_pkg::*;

    logic [6:0] r_fine,      n_fine;
    logic [7:0] r_coarse,    n_coarse;
    logic       r_cooling,   n_cooling;
    logic [7:0] r_step_cnt,  n_step_cnt;
    logic [6:0] r_remaining, n_remaining;
    logic       r_buzz_req,  n_buzz_req;
    logic [5:0] r_buzz_cnt,  n_buzz_cnt;
    t_out       res;

    always_comb begin
        logic       heat_any;
        logic       start;
        logic [6:0] fine_inc;
        logic [5:0] buzz_inc;

        heat_any    = i_item.heat_a_on | i_item.heat_b_on;
        n_cooling   = r_cooling;
        n_step_cnt  = r_step_cnt;
        n_remaining = r_remaining;
        n_buzz_req  = r_buzz_req;
        n_buzz_cnt  = r_buzz_cnt;
        res.cooldown_active = 1'b0;
        res.cooldown_done   = 1'b0;
        res.buzzer_drive    = 1'b0;
        res.report_kind     = KIND_NONE;
        res.report_value    = 8'd0;
        res.link_notify     = 1'b0;

        // Heating time: the fine count rolls over into the saturating coarse count.
        fine_inc = r_fine + {6'd0, heat_any};
        n_coarse = r_coarse;
        n_fine   = fine_inc;
        if (fine_inc > FINE_ROLL) begin
            if (r_coarse != 8'hFF) begin
                n_coarse = r_coarse + 8'd1;
            end
            n_fine = 7'd0;
        end
        start = 1'b0;
        if (!heat_any || !i_item.power_on) begin
            start = i_cfg.protect_enable && (n_coarse > i_cfg.heat_time_limit);
            n_fine   = 7'd0;
            n_coarse = 8'd0;
        end
        if (start) begin
            n_cooling       = 1'b1;
            res.link_notify = 1'b1;
        end

        // Cooldown stepping.
        if (n_cooling) begin
            if (r_step_cnt != 8'hFF) begin
                n_step_cnt = r_step_cnt + 8'd1;
            end
            if (n_step_cnt >= i_cfg.step_ticks) begin
                n_step_cnt = 8'd0;
                if (r_remaining != 7'd0) begin
                    n_remaining = r_remaining - 7'd1;
                end
                res.report_kind  = KIND_REMAIN;
                res.report_value = {1'b0, n_remaining};
            end
        end

        // The end check runs even when idle, so a zero reload ends every tick.
        if (n_remaining == 7'd0) begin
            n_cooling         = 1'b0;
            n_step_cnt        = 8'd0;
            n_remaining       = i_cfg.cooldown_steps;
            res.cooldown_done = 1'b1;
            res.report_kind   = KIND_END;
            res.report_value  = i_item.temperature;
            res.link_notify   = 1'b1;
        end else if (n_remaining == BUZZ_AT) begin
            n_buzz_req = 1'b1;
        end

        buzz_inc = r_buzz_cnt;
        if (n_buzz_req) begin
            res.buzzer_drive = 1'b1;
            buzz_inc = r_buzz_cnt + 6'd1;
        end
        n_buzz_cnt = buzz_inc;
        if (buzz_inc >= BUZZ_TICKS) begin
            n_buzz_req = 1'b0;
            n_buzz_cnt = 6'd0;
        end

        res.cooldown_active = n_cooling;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine      <= 7'd0;
            r_coarse    <= 8'd0;
            r_cooling   <= 1'b0;
            r_step_cnt  <= 8'd0;
            r_remaining <= RST_COOLDOWN_STEPS;
            r_buzz_req  <= 1'b0;
            r_buzz_cnt  <= 6'd0;
        end else if (i_step) begin
            r_fine      <= n_fine;
            r_coarse    <= n_coarse;
            r_cooling   <= n_cooling;
            r_step_cnt  <= n_step_cnt;
            r_remaining <= n_remaining;
            r_buzz_req  <= n_buzz_req;
            r_buzz_cnt  <= n_buzz_cnt;
        end
    end

    assign o_result = res;

endmodule

>>> rtl/overheat_protection_timer_core.sv
// ----------------------------------------------------------------------------
// overheat_protection_timer_core
// Heating-time guard that forces a timed fan cooldown after long heating.
// ----------------------------------------------------------------------------
// Each item is one tick. The block takes one item per clock cycle while the
// output side is ready and returns exactly one result per item: the item is
// registered, the whole tick update (heating count, cooldown step, buzzer
// timer) is done in one combinational pass against the state registers, and
// the result lands in an output register. Throughput is set by that single
// state-update path and is one item per cycle while the output side is ready.
// Configuration takes effect for items whose tick update runs after the write.
module overheat_protection_timer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: heat_a_on[0], heat_b_on[1], power_on[2], temperature[10:3], zeros
    input  logic [opt_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: cooldown_active[0], cooldown_done[1], buzzer_drive[2],
    //        report_value[10:3], link_notify[11], zeros
    output logic [opt_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // tuser: report_kind[1:0]
    output logic [opt_pkg::OUT_USER_W-1:0]  o_m_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [opt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [opt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import opt_pkg::*;

    t_cfg cfg;
    t_out result;
    t_in  r_in;
    logic r_in_valid;
    t_out r_out;
    logic r_out_valid;
    logic advance;
    logic step;
    logic in_accept;

    assign o_cfg_ready = 1'b1;

    opt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    opt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_s_tdata[$bits(t_in)-1:0];
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.report_kind;
    assign o_m_tdata  = {4'd0, r_out.link_notify, r_out.report_value, r_out.buzzer_drive,
                         r_out.cooldown_done, r_out.cooldown_active};

endmodule

>>> rtl/opt_checker.sv
// ----------------------------------------------------------------------------
// opt_checker
// Port-level checks of the overheat protection timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "overheat_protection_timer_core_assert.svh"

module opt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic [opt_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [opt_pkg::OUT_USER_W-1:0]  o_m_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready
);
    import opt_pkg::*;

    logic is_end;
    logic is_none;
    logic done_ok;
    logic end_ok;
    logic value_ok;
    logic kind_ok;
    logic stalled;
    logic [OUT_DATA_W+OUT_USER_W:0] hold_bits;

    assign is_end  = (o_m_tuser == KIND_END);
    assign is_none = (o_m_tuser == KIND_NONE);

    // The done flag and the end report always come together.
    assign done_ok = (o_m_tdata[1] == is_end);
    // An ending tick leaves the cooldown off and notifies the link side.
    assign end_ok = !o_m_tdata[1] || (!o_m_tdata[0] && o_m_tdata[11]);
    // Without a report the value field is zero.
    assign value_ok = !is_none || (o_m_tdata[10:3] == 8'd0);
    assign kind_ok = is_none || is_end || (o_m_tuser == KIND_REMAIN);
    assign stalled = o_m_tvalid && !i_m_tready;
    assign hold_bits = {o_m_tvalid, o_m_tuser, o_m_tdata};

    `OPT_ASSERT(a_done_is_end, i_clk, i_rst_n, o_m_tvalid |-> done_ok, "done without end")

    `OPT_ASSERT(a_end_state, i_clk, i_rst_n, o_m_tvalid |-> end_ok, "bad end tick")

    `OPT_ASSERT(a_no_report_value, i_clk, i_rst_n, o_m_tvalid |-> value_ok, "stray value")

    `OPT_ASSERT(a_kind_legal, i_clk, i_rst_n, o_m_tvalid |-> kind_ok, "unused report kind")

    // A stalled result stays put.
    `OPT_ASSERT(a_stall_hold, i_clk, i_rst_n, stalled |=> $stable(hold_bits), "result moved")

endmodule

bind overheat_protection_timer_core opt_checker u_opt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

>>> sim/tb_overheat_protection_timer_core.sv
// ----------------------------------------------------------------------------
// tb_overheat_protection_timer_core
// Self-checking bench for the overheat protection timer.
// ----------------------------------------------------------------------------
// A short table of hand-made ticks and register writes comes first, then
// fixed phases and random ones, each with a register setting and idling
// mode. Most traffic is heating bursts long enough to start a cooldown, the
// off tick that starts it, and enough ticks to let it run out. Results are
// compared with a tick-by-tick bench model or a checked table row's result.
module tb_overheat_protection_timer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import opt_pkg::*;

    localparam int RAND_TICKS  = 1840;
    localparam int PHASE_TICKS = 230;
    localparam int FIXED_PHASES = 7;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_op;

    typedef struct packed {
        t_row_op    op;
        t_reg_idx   idx;
        logic [7:0] data;
        t_in        tick;
        logic       checked;
        t_out       want;
    } t_row;

    localparam t_out QUIET = '0;

    // Tick fields are listed as temperature, power, heater B, heater A.
    localparam t_row DIR_ROWS [15] = '{
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'hFF, 1'b1, 1'b1, 1'b1}, 1'b1, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'h55, 1'b1, 1'b0, 1'b1}, 1'b1, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'hAA, 1'b0, 1'b1, 1'b0}, 1'b1, QUIET},
        '{ROW_WRITE, REG_PROTECT_ENABLE,  8'hFF, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
        '{ROW_WRITE, REG_HEAT_TIME_LIMIT, 8'h00, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'h0F, 1'b0, 1'b1, 1'b1}, 1'b1, QUIET},
        '{ROW_WRITE, REG_COOLDOWN_STEPS,  8'hFF, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
        '{ROW_WRITE, REG_STEP_TICKS,      8'h00, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'hF0, 1'b1, 1'b0, 1'b0}, 1'b1, QUIET},
        '{ROW_WRITE, REG_HEAT_TIME_LIMIT, 8'hFF, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'h3C, 1'b1, 1'b0, 1'b1}, 1'b0, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'hC3, 1'b1, 1'b1, 1'b0}, 1'b0, QUIET},
        '{ROW_WRITE, REG_PROTECT_ENABLE,  8'hFE, '{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
        '{ROW_TICK,  REG_PROTECT_ENABLE,  8'h00, '{8'h81, 1'b0, 1'b0, 1'b0}, 1'b1, QUIET}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic [OUT_USER_W-1:0]  o_m_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    overheat_protection_timer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state of the timer.
    t_cfg       cfg_now = '{RST_PROTECT_ENABLE, RST_HEAT_TIME_LIMIT,
                            RST_COOLDOWN_STEPS, RST_STEP_TICKS};
    logic [6:0] fine_cnt = '0;
    logic [7:0] coarse_cnt = '0;
    logic       cooling = 1'b0;
    logic [7:0] step_cnt = '0;
    logic [6:0] remaining_model = RST_COOLDOWN_STEPS;
    logic       buzz_req = 1'b0;
    logic [5:0] buzz_cnt = '0;

    t_out expected_ticks [$];
    bit   typed_pending = 1'b0;
    t_out typed_result = '0;

    int ticks_in = 0;
    int sent_ticks = 0;
    int writes_done = 0;
    int results_seen = 0;
    int faults = 0;
    int ends_seen = 0;
    int count_reports = 0;
    int buzz_ticks = 0;
    int settings_used = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;
    int phase_end = 0;

    function automatic t_out tick_outcome(input t_in it);
        t_out r;
        logic heating;
        r = '0;
        heating = it.heat_a_on | it.heat_b_on;

        if (heating) fine_cnt = fine_cnt + 7'd1;
        if (fine_cnt > FINE_ROLL) begin
            if (coarse_cnt != 8'hFF) coarse_cnt = coarse_cnt + 8'd1;
            fine_cnt = '0;
        end
        if (!heating || !it.power_on) begin
            if (cfg_now.protect_enable && coarse_cnt > cfg_now.heat_time_limit) begin
                cooling = 1'b1;
                r.link_notify = 1'b1;
            end
            fine_cnt = '0;
            coarse_cnt = '0;
        end

        if (cooling) begin
            if (step_cnt != 8'hFF) step_cnt = step_cnt + 8'd1;
            if (step_cnt >= cfg_now.step_ticks) begin
                step_cnt = '0;
                if (remaining_model != 0) remaining_model = remaining_model - 7'd1;
                r.report_kind = KIND_REMAIN;
                r.report_value = {1'b0, remaining_model};
            end
        end
        // The end check runs whether or not a cooldown is in progress.
        if (remaining_model == 0) begin
            cooling = 1'b0;
            step_cnt = '0;
            remaining_model = cfg_now.cooldown_steps;
            r.cooldown_done = 1'b1;
            r.report_kind = KIND_END;
            r.report_value = it.temperature;
            r.link_notify = 1'b1;
        end else if (remaining_model == BUZZ_AT) begin
            buzz_req = 1'b1;
        end

        if (buzz_req) begin
            r.buzzer_drive = 1'b1;
            buzz_cnt = buzz_cnt + 6'd1;
        end
        if (buzz_cnt >= BUZZ_TICKS) begin
            buzz_req = 1'b0;
            buzz_cnt = '0;
        end

        r.cooldown_active = cooling;
        return r;
    endfunction

    function automatic string show(input t_out r);
        return $sformatf("active=%0b done=%0b buzz=%0b kind=%0d value=%0d link=%0b",
                         r.cooldown_active, r.cooldown_done, r.buzzer_drive,
                         r.report_kind, r.report_value, r.link_notify);
    endfunction

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_out got;
        t_out want;
        t_out pred;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '0;
                got.cooldown_active = o_m_tdata[0];
                got.cooldown_done   = o_m_tdata[1];
                got.buzzer_drive    = o_m_tdata[2];
                got.report_value    = o_m_tdata[10:3];
                got.link_notify     = o_m_tdata[11];
                got.report_kind     = t_report_kind'(o_m_tuser);
                results_seen++;
                if (expected_ticks.size() == 0) begin
                    if (faults < 10) $display("unexpected result: %s", show(got));
                    faults++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.cooldown_active !== want.cooldown_active ||
                        got.cooldown_done   !== want.cooldown_done   ||
                        got.buzzer_drive    !== want.buzzer_drive    ||
                        got.report_kind     !== want.report_kind     ||
                        got.report_value    !== want.report_value    ||
                        got.link_notify     !== want.link_notify) begin
                        if (faults < 10) begin
                            $display("mismatch on result %0d", results_seen);
                            $display("  want %s", show(want));
                            $display("  got  %s", show(got));
                        end
                        faults++;
                    end
                end
            end

            if (i_s_tvalid && o_s_tready) begin
                pred = tick_outcome(t_in'(i_s_tdata[10:0]));
                if (pred.cooldown_done) ends_seen++;
                if (pred.report_kind == KIND_REMAIN) count_reports++;
                if (pred.buzzer_drive) buzz_ticks++;
                expected_ticks.push_back(typed_pending ? typed_result : pred);
                ticks_in++;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PROTECT_ENABLE:  cfg_now.protect_enable  = i_cfg_data[0];
                    REG_HEAT_TIME_LIMIT: cfg_now.heat_time_limit = i_cfg_data;
                    REG_COOLDOWN_STEPS:  cfg_now.cooldown_steps  = i_cfg_data[6:0];
                    REG_STEP_TICKS:      cfg_now.step_ticks      = i_cfg_data;
                    default: ;
                endcase
                writes_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_ticks.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(input t_in it, input bit typed, input t_out want);
        int target;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        typed_pending = typed;
        typed_result = want;
        target = ticks_in + 1;
        i_s_tdata <= {{(IN_DATA_W - 11){1'b0}}, it};
        i_s_tvalid <= 1'b1;
        do @(negedge i_clk); while (ticks_in < target);
        sent_ticks++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] data);
        int target;
        target = writes_done + 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (writes_done < target);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        typed_pending = 1'b0;
        while (expected_ticks.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_in random_tick();
        return t_in'($urandom_range(0, 2047));
    endfunction

    // One stretch of traffic: mostly a heating burst that should arm the
    // cooldown, the off tick that starts it, and ticks while it runs out.
    // A stretch never runs past the end of the current phase.
    task automatic run_stretch();
        int pick;
        int burst;
        int follow;
        int left;
        t_in it;
        left = phase_end - sent_ticks;
        if (left <= 0) return;
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            repeat ($urandom_range(1, (left < 40) ? left : 40))
                send_tick(random_tick(), 1'b0, QUIET);
            return;
        end
        if (pick >= 70) burst = $urandom_range(1, 100);
        else if (cfg_now.heat_time_limit <= 3)
            burst = (cfg_now.heat_time_limit + 1) * 101 + $urandom_range(0, 40);
        else burst = $urandom_range(50, 300);
        if (burst > left - 1) burst = left - 1;

        repeat (burst) begin
            it = random_tick();
            {it.heat_b_on, it.heat_a_on} = 2'($urandom_range(1, 3));
            it.power_on = 1'b1;
            send_tick(it, 1'b0, QUIET);
        end
        it = random_tick();
        if ($urandom_range(0, 1) != 0) {it.heat_b_on, it.heat_a_on} = 2'b00;
        else it.power_on = 1'b0;
        send_tick(it, 1'b0, QUIET);

        follow = remaining_model * ((cfg_now.step_ticks == 0) ? 1 : cfg_now.step_ticks)
                 + $urandom_range(2, 20);
        if (follow > 400) follow = 400;
        if (follow > left - burst - 1) follow = left - burst - 1;
        repeat (follow) send_tick(random_tick(), 1'b0, QUIET);
    endtask

    initial begin : stimulus
        int ph;
        int rand_start;
        logic       pe;
        logic [7:0] lim;
        logic [7:0] steps;
        logic [7:0] st;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].op == ROW_WRITE) begin
                wait_drained();
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end else begin
                send_tick(DIR_ROWS[r].tick, DIR_ROWS[r].checked, DIR_ROWS[r].want);
            end
        end

        rand_start = sent_ticks;
        for (ph = 0; ph < FIXED_PHASES || sent_ticks - rand_start < RAND_TICKS; ph++) begin
            wait_drained();
            // The fixed settings come first; each cooldown starts from the reload
            // left by the phase before.
            case (ph)
                0: {pe, lim, steps, st} = {1'b1, 8'd0,   8'd1,  8'd1};
                1: {pe, lim, steps, st} = {1'b1, 8'd0,   8'd1,  8'd255};
                2: {pe, lim, steps, st} = {1'b1, 8'd0,   8'd0,  8'd0};
                3: {pe, lim, steps, st} = {1'b1, 8'd1,   8'd10, 8'd2};
                4: {pe, lim, steps, st} = {1'b1, 8'd0,   8'd12, 8'd3};
                5: {pe, lim, steps, st} = {1'b1, 8'd255, 8'd99, 8'd255};
                6: {pe, lim, steps, st} = {1'b0, 8'd0,   8'd5,  8'd1};
                default: begin
                    pe = ($urandom_range(0, 5) != 0);
                    lim = 8'($urandom_range(0, 2));
                    steps = ($urandom_range(0, 5) == 0) ? 8'd99 : 8'($urandom_range(0, 15));
                    st = 8'($urandom_range(0, 8));
                end
            endcase
            // Upper bits beyond each register's width must be dropped.
            write_reg(REG_PROTECT_ENABLE, {7'($urandom_range(0, 127)), pe});
            write_reg(REG_HEAT_TIME_LIMIT, lim);
            write_reg(REG_COOLDOWN_STEPS, {1'($urandom_range(0, 1)), steps[6:0]});
            write_reg(REG_STEP_TICKS, st);
            settings_used++;

            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            phase_end = sent_ticks + PHASE_TICKS;
            while (sent_ticks < phase_end) run_stretch();
        end

        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("Ran %0d ticks under %0d register settings and four idling modes.",
                 ticks_in, settings_used);
        $display("Seen %0d cooldown ends, %0d count reports, %0d buzzer ticks; %0d faults.",
                 ends_seen, count_reports, buzz_ticks, faults);
        if (faults == 0 && expected_ticks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/opt_pkg.sv
rtl/opt_cfg.sv
rtl/opt_core.sv
rtl/overheat_protection_timer_core.sv
rtl/opt_checker.sv
sim/tb_overheat_protection_timer_core.sv
